>>> sv/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the lift position controller: command and
// direction codes, register indexes, request and response words.
// ----------------------------------------------------------------------------
package lpc_pkg;

	// position counter width and reset values
	localparam int POSITION_BITS_DEF = 10;
	localparam int LOWER_LIMIT_RESET = 0;
	localparam int UPPER_LIMIT_RESET = 1000;
	localparam int START_POSITION_RESET = 500;

	// register file
	localparam int CFG_DATA_W = 10;
	localparam int CFG_ADDR_W = 2;

	// fixed field widths of the channel words
	localparam int POS_OUT_W = 10;
	localparam int TARGET_IN_W = 11;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LOWER_LIMIT = 2'd0,
		REG_UPPER_LIMIT = 2'd1,
		REG_START_POS   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_TICK         = 3'd0,
		CMD_MOVE         = 3'd1,
		CMD_SET_TARGET   = 3'd2,
		CMD_CLEAR_TARGET = 3'd3,
		CMD_SET_SWITCH   = 3'd4,
		CMD_TOGGLE       = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// request word
	typedef struct packed {
		cmd_t                   command;
		logic [1:0]             direction;
		logic [TARGET_IN_W-1:0] target_value;
		logic                   switch_value;
	} lpc_req_t;

	// response word
	typedef struct packed {
		logic                 motor_up;
		logic                 motor_down;
		logic [POS_OUT_W-1:0] position_now;
		logic [POS_OUT_W-1:0] target_now;
		logic                 target_active;
		logic                 switch_state;
		logic                 changed;
	} lpc_rsp_t;

	// control state passed between the state registers and the update logic
	typedef struct packed {
		dir_t travel_dir;
		logic goal_valid;
		logic power_state;
	} lpc_ctrl_t;

endpackage

>>> sv/lpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpc_cfg_regs
// Limit registers. Values are kept at the narrower of the register and
// counter widths; the start position index stores nothing, so a write to it
// is ignored and has no effect on the live position.
// ----------------------------------------------------------------------------
module lpc_cfg_regs
	import lpc_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	output logic [POSITION_BITS-1:0] lo_lim,
	output logic [POSITION_BITS-1:0] hi_lim
);

	// stored bits: the register width, cut to the counter width when narrower
	localparam int LIM_W = (POSITION_BITS < CFG_DATA_W) ? POSITION_BITS : CFG_DATA_W;

	logic [LIM_W-1:0] lower_q;
	logic [LIM_W-1:0] upper_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LIM_W'(LOWER_LIMIT_RESET);
			upper_q <= LIM_W'(UPPER_LIMIT_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_LOWER_LIMIT: lower_q <= cfg_wdata[LIM_W-1:0];
				REG_UPPER_LIMIT: upper_q <= cfg_wdata[LIM_W-1:0];
				default: ; // start position and unused index: nothing stored
			endcase
		end
	end

	assign lo_lim = POSITION_BITS'(lower_q);
	assign hi_lim = POSITION_BITS'(upper_q);

endmodule

>>> sv/lpc_step.sv
// ----------------------------------------------------------------------------
// lpc_step
// Next-state logic for one request word: tick stepping with limit and target
// stop, move start, target clamp and compare, switch commands.
// ----------------------------------------------------------------------------
module lpc_step
	import lpc_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  lpc_req_t                 req,
	input  logic [POSITION_BITS-1:0] pos,
	input  logic [POSITION_BITS-1:0] goal,
	input  lpc_ctrl_t                ctrl,
	input  logic [POSITION_BITS-1:0] lo_lim,
	input  logic [POSITION_BITS-1:0] hi_lim,
	output logic [POSITION_BITS-1:0] pos_nxt,
	output logic [POSITION_BITS-1:0] goal_nxt,
	output lpc_ctrl_t                ctrl_nxt,
	output logic                     changed
);

	// compare width for the raw target against the limits
	localparam int CMP_W = (POSITION_BITS > TARGET_IN_W) ? POSITION_BITS : TARGET_IN_W;

	logic [CMP_W-1:0]         tgt_raw;
	logic [CMP_W-1:0]         lo_c;
	logic [CMP_W-1:0]         hi_c;
	logic [CMP_W-1:0]         tgt_clamp;
	logic [POSITION_BITS-1:0] tgt;
	logic [POSITION_BITS-1:0] pos_step;
	logic                     hit;
	logic                     stop;
	dir_t                     move_req;

	// move start: refused at the limit in the requested direction
	function automatic dir_t start_dir(dir_t want, logic [POSITION_BITS-1:0] p,
			logic [POSITION_BITS-1:0] lo, logic [POSITION_BITS-1:0] hi);
		dir_t d;
		d = DIR_NONE;
		if (want == DIR_UP && p < hi)
			d = DIR_UP;
		else if (want == DIR_DOWN && p > lo)
			d = DIR_DOWN;
		return d;
	endfunction

	// target clamp: lower limit first, then upper; result always fits the counter
	assign tgt_raw = CMP_W'(req.target_value);
	assign lo_c    = CMP_W'(lo_lim);
	assign hi_c    = CMP_W'(hi_lim);
	always_comb begin
		if (tgt_raw < lo_c)
			tgt_clamp = lo_c;
		else if (tgt_raw > hi_c)
			tgt_clamp = hi_c;
		else
			tgt_clamp = tgt_raw;
	end
	assign tgt = tgt_clamp[POSITION_BITS-1:0];

	// requested move direction; codes 0 and 3 mean stop
	always_comb begin
		case (req.direction)
			DIR_UP:   move_req = DIR_UP;
			DIR_DOWN: move_req = DIR_DOWN;
			default:  move_req = DIR_NONE;
		endcase
	end

	// saturating step and stop tests for a tick
	always_comb begin
		pos_step = pos;
		hit      = 1'b0;
		stop     = 1'b0;
		if (ctrl.travel_dir == DIR_DOWN) begin
			if (pos != '0)
				pos_step = pos - POSITION_BITS'(1);
			hit  = ctrl.goal_valid && (pos_step <= goal);
			stop = pos_step <= lo_lim;
		end else if (ctrl.travel_dir == DIR_UP) begin
			if (pos != '1)
				pos_step = pos + POSITION_BITS'(1);
			hit  = ctrl.goal_valid && (pos_step >= goal);
			stop = pos_step >= hi_lim;
		end
	end

	// command decode
	always_comb begin
		pos_nxt  = pos;
		goal_nxt = goal;
		ctrl_nxt = ctrl;
		changed  = 1'b0;
		unique case (req.command)
			CMD_TICK: begin
				if (ctrl.travel_dir != DIR_NONE) begin
					pos_nxt = pos_step;
					changed = 1'b1;
					if (stop || hit)
						ctrl_nxt.travel_dir = DIR_NONE;
					if (hit)
						ctrl_nxt.goal_valid = 1'b0;
				end
			end
			CMD_MOVE: begin
				ctrl_nxt.travel_dir = start_dir(move_req, pos, lo_lim, hi_lim);
				changed = 1'b1;
			end
			CMD_SET_TARGET: begin
				if (!(tgt == pos || (ctrl.goal_valid && tgt == goal))) begin
					goal_nxt            = tgt;
					ctrl_nxt.goal_valid = 1'b1;
					ctrl_nxt.travel_dir = start_dir((tgt < pos) ? DIR_DOWN : DIR_UP,
						pos, lo_lim, hi_lim);
					changed = 1'b1;
				end
			end
			CMD_CLEAR_TARGET: begin
				ctrl_nxt.goal_valid = 1'b0;
				ctrl_nxt.travel_dir = DIR_NONE;
				changed = 1'b1;
			end
			CMD_SET_SWITCH: begin
				if (ctrl.power_state != req.switch_value) begin
					ctrl_nxt.power_state = req.switch_value;
					changed = 1'b1;
				end
			end
			CMD_TOGGLE: begin
				ctrl_nxt.power_state = !ctrl.power_state;
				changed = 1'b1;
			end
			default: ; // unused codes: no change
		endcase
	end

endmodule

>>> sv/tick_counted_lift_position_controller.sv
// ----------------------------------------------------------------------------
// tick_counted_lift_position_controller
// Lift position controller counting encoder ticks: motor drive, position,
// optional target and power switch, one response word per request word.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_valid/req_ready) carry a command: encoder tick, move,
//   set or clear target, set or toggle the power switch. Every request word
//   gives exactly one response word (rsp_valid/rsp_ready) with the motor
//   drives, position, target, switch state and a changed flag.
//   The limit registers are written through cfg_wr_en/cfg_addr/cfg_wdata while
//   no word is in flight; a write takes effect on the next word.
//   The input register holds an accepted word until the response register is
//   free or being emptied; the word is then processed into the response
//   register, which raises rsp_valid.
//   Throughput: one word per cycle while responses are taken; the update
//   is one pass of logic from input to state and response registers.
//   Stall: while the response is not taken, one more word waits in the input
//   register, then req_ready drops until the response leaves.
//   Reset: the motor is stopped, no target, switch off, and the position is
//   loaded with the start position reset value (500, cut to the counter).
// ----------------------------------------------------------------------------
module tick_counted_lift_position_controller
	import lpc_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  lpc_req_t              req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output lpc_rsp_t              rsp
);

	logic [POSITION_BITS-1:0] lo_lim;
	logic [POSITION_BITS-1:0] hi_lim;

	logic                     valid_s1;
	lpc_req_t                 req_s1;
	logic                     advance;

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] goal_q;
	lpc_ctrl_t                ctrl_q;

	logic [POSITION_BITS-1:0] pos_nxt;
	logic [POSITION_BITS-1:0] goal_nxt;
	lpc_ctrl_t                ctrl_nxt;
	logic                     changed;

	logic                     rsp_valid_q;
	lpc_rsp_t                 rsp_q;

	lpc_cfg_regs #(
		.POSITION_BITS(POSITION_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.lo_lim   (lo_lim),
		.hi_lim   (hi_lim)
	);

	lpc_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.req     (req_s1),
		.pos     (pos_q),
		.goal    (goal_q),
		.ctrl    (ctrl_q),
		.lo_lim  (lo_lim),
		.hi_lim  (hi_lim),
		.pos_nxt (pos_nxt),
		.goal_nxt(goal_nxt),
		.ctrl_nxt(ctrl_nxt),
		.changed (changed)
	);

	// handshake: process when the response register is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POSITION_BITS'(START_POSITION_RESET);
			goal_q <= '0;
			ctrl_q <= '{travel_dir: DIR_NONE, goal_valid: 1'b0, power_state: 1'b0};
		end else if (advance) begin
			pos_q  <= pos_nxt;
			goal_q <= goal_nxt;
			ctrl_q <= ctrl_nxt;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.motor_up      <= (ctrl_nxt.travel_dir == DIR_UP);
			rsp_q.motor_down    <= (ctrl_nxt.travel_dir == DIR_DOWN);
			rsp_q.position_now  <= POS_OUT_W'(pos_nxt);
			rsp_q.target_now    <= ctrl_nxt.goal_valid ? POS_OUT_W'(goal_nxt) : '0;
			rsp_q.target_active <= ctrl_nxt.goal_valid;
			rsp_q.switch_state  <= ctrl_nxt.power_state;
			rsp_q.changed       <= changed;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// the two motor drives are never on together
	a_motor_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.motor_up && rsp_q.motor_down))
		else $error("both motor drives on");

	// an inactive target reads as zero
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.target_active) |-> (rsp_q.target_now == '0))
		else $error("target reported while inactive");

	// only a tick moves the position
	a_pos_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.command != CMD_TICK) |=> $stable(pos_q))
		else $error("position moved without a tick");

	// a tick while stopped changes nothing
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.command == CMD_TICK && ctrl_q.travel_dir == DIR_NONE)
		|=> (!rsp_q.changed && $stable(pos_q)))
		else $error("idle tick reported a change");

	// back pressure only with both stages full and the response stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && rsp_valid_q && !rsp_ready))
		else $error("input stalled without cause");
`endif

endmodule

>>> verif/lpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// Watches the register port and both word channels of the lift position
// controller, keeps its own copy of the position, travel, target and switch
// state, and compares every response word field by field with the status
// predicted for the oldest request word still waiting.
// ----------------------------------------------------------------------------
module lpc_checker
	import lpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  lpc_req_t              req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  lpc_rsp_t              rsp,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int POS_MAX = (1 << POSITION_BITS_DEF) - 1;

	// shadow of the limit registers and of the controller state
	logic [CFG_DATA_W-1:0]        lower_reg;
	logic [CFG_DATA_W-1:0]        upper_reg;
	logic [CFG_DATA_W-1:0]        start_reg;
	logic [POSITION_BITS_DEF-1:0] pos_cnt;
	logic [POSITION_BITS_DEF-1:0] goal_pos;
	dir_t                         travel;
	logic                         goal_on;
	logic                         power_on;

	// status words owed to the response channel, oldest first
	lpc_rsp_t status_due_q[$];

	// stop, then take the requested direction if the limit allows it
	function automatic void begin_travel(logic [1:0] d);
		travel = DIR_NONE;
		if (d == DIR_UP && int'(pos_cnt) < (int'(upper_reg) & POS_MAX))
			travel = DIR_UP;
		else if (d == DIR_DOWN && int'(pos_cnt) > (int'(lower_reg) & POS_MAX))
			travel = DIR_DOWN;
	endfunction

	// apply one request word to the shadow state, return the status it yields
	function automatic lpc_rsp_t advance_lift(lpc_req_t w);
		int       lo_b;
		int       hi_b;
		int       p;
		int       t;
		logic     hit;
		logic     at_limit;
		logic     chg;
		lpc_rsp_t r;
		lo_b     = int'(lower_reg) & POS_MAX;
		hi_b     = int'(upper_reg) & POS_MAX;
		p        = int'(pos_cnt);
		hit      = 1'b0;
		at_limit = 1'b0;
		chg      = 1'b0;
		case (w.command)
			CMD_TICK: begin
				// one encoder step while travelling, saturating at the counter ends
				if (travel == DIR_DOWN) begin
					if (p > 0)
						p--;
					hit      = goal_on && p <= int'(goal_pos);
					at_limit = p <= lo_b;
					chg      = 1'b1;
				end else if (travel == DIR_UP) begin
					if (p < POS_MAX)
						p++;
					hit      = goal_on && p >= int'(goal_pos);
					at_limit = p >= hi_b;
					chg      = 1'b1;
				end
				pos_cnt = p[POSITION_BITS_DEF-1:0];
				if (hit || at_limit)
					travel = DIR_NONE;
				if (hit)
					goal_on = 1'b0;
			end
			CMD_MOVE: begin
				begin_travel(w.direction);
				chg = 1'b1;
			end
			CMD_SET_TARGET: begin
				// clamp low first, then high; no-op on current position or same goal
				t = int'(w.target_value);
				if (t < lo_b)
					t = lo_b;
				else if (t > hi_b)
					t = hi_b;
				if (!(t == p || (goal_on && t == int'(goal_pos)))) begin
					goal_pos = t[POSITION_BITS_DEF-1:0];
					goal_on  = 1'b1;
					begin_travel(t < p ? DIR_DOWN : DIR_UP);
					chg = 1'b1;
				end
			end
			CMD_CLEAR_TARGET: begin
				goal_on = 1'b0;
				travel  = DIR_NONE;
				chg     = 1'b1;
			end
			CMD_SET_SWITCH: begin
				if (power_on != w.switch_value) begin
					power_on = w.switch_value;
					chg      = 1'b1;
				end
			end
			CMD_TOGGLE: begin
				power_on = !power_on;
				chg      = 1'b1;
			end
			default: ;
		endcase
		r.motor_up      = travel == DIR_UP;
		r.motor_down    = travel == DIR_DOWN;
		r.position_now  = pos_cnt;
		r.target_now    = goal_on ? goal_pos : '0;
		r.target_active = goal_on;
		r.switch_state  = power_on;
		r.changed       = chg;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t lpc_checker: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// pop and compare responses, track register writes, predict requests
	always @(posedge clk or negedge arst_n) begin
		lpc_rsp_t want;
		if (!arst_n) begin
			lower_reg  = CFG_DATA_W'(LOWER_LIMIT_RESET);
			upper_reg  = CFG_DATA_W'(UPPER_LIMIT_RESET);
			start_reg  = CFG_DATA_W'(START_POSITION_RESET);
			pos_cnt    = POSITION_BITS_DEF'(START_POSITION_RESET & POS_MAX);
			goal_pos   = '0;
			travel     = DIR_NONE;
			goal_on    = 1'b0;
			power_on   = 1'b0;
			fail_count = 0;
			status_due_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (status_due_q.size() == 0) begin
					$display("%0t lpc_checker: response word %h expected none",
						$time, rsp);
					fail_count++;
				end else begin
					want = status_due_q.pop_front();
					check_field("motor_up", want.motor_up, rsp.motor_up);
					check_field("motor_down", want.motor_down, rsp.motor_down);
					check_field("position_now", want.position_now, rsp.position_now);
					check_field("target_now", want.target_now, rsp.target_now);
					check_field("target_active", want.target_active, rsp.target_active);
					check_field("switch_state", want.switch_state, rsp.switch_state);
					check_field("changed", want.changed, rsp.changed);
				end
			end
			// start_reg is tracked but never used; the position is not reloaded
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_LOWER_LIMIT: lower_reg = cfg_wdata;
					REG_UPPER_LIMIT: upper_reg = cfg_wdata;
					REG_START_POS:   start_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				status_due_q.push_back(advance_lift(req));
			outstanding <= status_due_q.size();
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the lift position controller. Drives a directed opening, a
// long climb to the top of the counter, then random command words under
// several limit settings and handshake idling patterns, with one long
// response hold-off; the checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module tb;
	import lpc_pkg::*;

	// command and direction codes with no name in the package
	localparam cmd_t       CMD_SPARE_6 = cmd_t'(3'd6);
	localparam cmd_t       CMD_SPARE_7 = cmd_t'(3'd7);
	localparam logic [1:0] DIR_SPARE   = 2'd3;

	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_WORDS = 90;
	localparam int NUM_PHASES  = 7;
	localparam int CLIMB_TICKS = 560;

	// limit settings and idling per random phase
	int lo_tab[NUM_PHASES] = '{1000, 800,  480, 0,  1023, 0,    490};
	int hi_tab[NUM_PHASES] = '{1023, 200,  530, 0,  0,    1000, 510};
	int sp_tab[NUM_PHASES] = '{0,    700,  5,   0,  1023, 500,  682};
	int tx_tab[NUM_PHASES] = '{0,    82,   0,   12, 0,    82,   0};
	int rx_tab[NUM_PHASES] = '{0,    0,    82,  12, 0,    0,    82};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	lpc_req_t              req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	lpc_rsp_t              rsp;

	int fail_count;
	int outstanding;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_asks    = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	tick_counted_lift_position_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	lpc_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// response side: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= $urandom_range(99) >= rx_stall_pct;
		end
	end

	// watchdog: too long with no word moving on any port
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic lpc_req_t make_word(cmd_t c, logic [1:0] d, logic [10:0] t, logic s);
		lpc_req_t w;
		w.command      = c;
		w.direction    = d;
		w.target_value = t;
		w.switch_value = s;
		return w;
	endfunction

	// random command word, targets mostly around the current limit band
	function automatic lpc_req_t random_word(int lo_v, int hi_v);
		int       a;
		int       b;
		int       r;
		lpc_req_t w;
		a = lo_v < hi_v ? lo_v : hi_v;
		b = lo_v < hi_v ? hi_v : lo_v;
		w.direction    = 2'($urandom_range(3));
		w.switch_value = 1'($urandom_range(1));
		if ($urandom_range(9) < 7)
			w.target_value = 11'($urandom_range(b + 8, a < 8 ? 0 : a - 8));
		else
			w.target_value = 11'($urandom_range(2047));
		r = $urandom_range(99);
		if (r < 55)
			w.command = CMD_TICK;
		else if (r < 65)
			w.command = CMD_MOVE;
		else if (r < 77)
			w.command = CMD_SET_TARGET;
		else if (r < 82)
			w.command = CMD_CLEAR_TARGET;
		else if (r < 88)
			w.command = CMD_SET_SWITCH;
		else if (r < 94)
			w.command = CMD_TOGGLE;
		else
			w.command = r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
		return w;
	endfunction

	// offer one request word after a random gap, return once it is taken
	task automatic send_word(lpc_req_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// stop offering and wait until every response word has come back
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_limits(int lo_v, int hi_v, int sp_v);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= REG_LOWER_LIMIT;
		cfg_wdata <= CFG_DATA_W'(lo_v);
		@(posedge clk);
		cfg_addr  <= REG_UPPER_LIMIT;
		cfg_wdata <= CFG_DATA_W'(hi_v);
		@(posedge clk);
		cfg_addr  <= REG_START_POS;
		cfg_wdata <= CFG_DATA_W'(sp_v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening on the reset limits, position at 500
		send_word(make_word(CMD_SET_TARGET, DIR_NONE, 11'd500, 1'b0)); // on position: no-op
		send_word(make_word(CMD_TICK, DIR_SPARE, 11'h7ff, 1'b1));      // tick while idle
		send_word(make_word(CMD_TOGGLE, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_SET_SWITCH, DIR_NONE, 11'd0, 1'b1));   // already on
		send_word(make_word(CMD_SET_SWITCH, DIR_UP, 11'h7ff, 1'b0));
		send_word(make_word(CMD_MOVE, DIR_UP, 11'd0, 1'b0));
		send_word(make_word(CMD_TICK, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_TICK, DIR_DOWN, 11'd1365, 1'b1));
		send_word(make_word(CMD_MOVE, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_MOVE, DIR_SPARE, 11'd0, 1'b0));
		send_word(make_word(CMD_MOVE, DIR_DOWN, 11'd682, 1'b0));
		send_word(make_word(CMD_TICK, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_SET_TARGET, DIR_NONE, 11'h7ff, 1'b0)); // clamps high
		send_word(make_word(CMD_SET_TARGET, DIR_NONE, 11'd1000, 1'b0)); // same goal
		send_word(make_word(CMD_TICK, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_CLEAR_TARGET, DIR_UP, 11'd0, 1'b1));
		send_word(make_word(CMD_SET_TARGET, DIR_NONE, 11'd0, 1'b0));   // goal at zero
		send_word(make_word(CMD_TICK, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_SPARE_6, DIR_SPARE, 11'h7ff, 1'b1));
		send_word(make_word(CMD_SPARE_7, DIR_UP, 11'd0, 1'b0));
		send_word(make_word(CMD_MOVE, DIR_DOWN, 11'd0, 1'b0));
		send_word(make_word(CMD_TICK, DIR_NONE, 11'd0, 1'b0));
		send_word(make_word(CMD_CLEAR_TARGET, DIR_NONE, 11'd0, 1'b0));

		// full-range limits, then climb to the top of the counter
		drain();
		repeat (3) @(posedge clk);
		set_limits(0, 1023, 1023);
		send_word(make_word(CMD_SET_TARGET, DIR_SPARE, 11'h7ff, 1'b1));
		repeat (CLIMB_TICKS)
			send_word(make_word(CMD_TICK, 2'($urandom_range(3)), 11'($urandom_range(2047)),
				1'($urandom_range(1))));

		// random phases, each on its own limits and idling pattern
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			repeat (3) @(posedge clk);
			set_limits(lo_tab[ph], hi_tab[ph], sp_tab[ph]);
			tx_idle_pct  <= tx_tab[ph];
			rx_stall_pct <= rx_tab[ph];
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// fill the block behind a held response, later pause until empty
				if (ph == 0 && n == 40)
					hold_asks <= hold_asks + 1;
				if (ph == 0 && n == 70)
					drain();
				send_word(random_word(lo_tab[ph], hi_tab[ph]));
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
